// ===== rtl/ladsr_pkg.sv =====
// ============================================================================
// ladsr_pkg
// Shared types, constants and the time table for the linear ADSR envelope.
// ============================================================================
package ladsr_pkg;

    // Level format: unsigned, 1.0 = 2^LEVEL_FRAC_BITS
    localparam int LEVEL_FRAC_BITS    = 24;
    localparam int LEVEL_W            = LEVEL_FRAC_BITS + 1;
    localparam int TIME_TABLE_ENTRIES = 128;
    localparam int CODE_W             = 7;
    localparam int TICK_W             = 16;
    localparam int TICK_FRAC_BITS     = 8;
    localparam int MS_W               = 15;
    localparam int VEL_NUM_W          = 14;
    localparam int PROD_W             = LEVEL_W + TICK_W;
    localparam int DIV_W              = LEVEL_FRAC_BITS + VEL_NUM_W;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 16;

    localparam logic [LEVEL_W-1:0]    ONE_LEVEL  = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [CODE_W-1:0]     CODE_MAX   = 7'd127;
    localparam logic [VEL_NUM_W-1:0]  VEL_FULL   = 14'd16129;   // 127 * 127
    localparam logic [TICK_W-1:0]     Q8_ROUND   = 16'd255;

    localparam logic [CODE_W-1:0]     TIME_CODE_RESET = 7'd64;
    localparam logic [CODE_W-1:0]     SUSTAIN_RESET   = 7'd64;
    localparam logic [CODE_W-1:0]     SENS_RESET      = 7'd0;
    localparam logic [TICK_W-1:0]     TICK_RESET      = 16'd256;

    // Exponential duration table, milliseconds
    localparam logic [MS_W-1:0] MS_TABLE [TIME_TABLE_ENTRIES] = '{
        15'd1,     15'd8,     15'd16,    15'd25,    15'd34,    15'd44,    15'd53,    15'd63,
        15'd74,    15'd85,    15'd96,    15'd108,   15'd121,   15'd134,   15'd147,   15'd161,
        15'd175,   15'd191,   15'd206,   15'd223,   15'd240,   15'd257,   15'd276,   15'd295,
        15'd315,   15'd335,   15'd357,   15'd379,   15'd402,   15'd426,   15'd452,   15'd478,
        15'd505,   15'd533,   15'd563,   15'd593,   15'd625,   15'd658,   15'd693,   15'd729,
        15'd766,   15'd805,   15'd845,   15'd887,   15'd931,   15'd976,   15'd1023,  15'd1072,
        15'd1124,  15'd1177,  15'd1232,  15'd1289,  15'd1349,  15'd1412,  15'd1476,  15'd1544,
        15'd1614,  15'd1686,  15'd1762,  15'd1841,  15'd1923,  15'd2008,  15'd2097,  15'd2189,
        15'd2285,  15'd2385,  15'd2489,  15'd2596,  15'd2709,  15'd2826,  15'd2947,  15'd3073,
        15'd3205,  15'd3342,  15'd3484,  15'd3632,  15'd3786,  15'd3946,  15'd4112,  15'd4285,
        15'd4465,  15'd4653,  15'd4848,  15'd5050,  15'd5261,  15'd5480,  15'd5708,  15'd5946,
        15'd6193,  15'd6449,  15'd6716,  15'd6994,  15'd7283,  15'd7583,  15'd7896,  15'd8221,
        15'd8559,  15'd8911,  15'd9277,  15'd9657,  15'd10053, 15'd10465, 15'd10893, 15'd11338,
        15'd11802, 15'd12284, 15'd12785, 15'd13306, 15'd13849, 15'd14413, 15'd15000, 15'd15610,
        15'd16245, 15'd16905, 15'd17592, 15'd18306, 15'd19050, 15'd19823, 15'd20627, 15'd21463,
        15'd22333, 15'd23238, 15'd24179, 15'd25158, 15'd26176, 15'd27235, 15'd28337, 15'd29483
    };

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_SUSTAIN = 3'd2,
        CFG_RELEASE = 3'd3,
        CFG_SENS    = 3'd4,
        CFG_TICK    = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_NOTE_ON  = 2'd1,
        ACT_NOTE_OFF = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_DECAY   = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        MUL_VEL  = 2'd0,
        MUL_SUS  = 2'd1,
        MUL_STEP = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_PEAK = 2'd0,
        DIV_SUS  = 2'd1,
        DIV_STEP = 2'd2
    } t_div_sel;

    typedef struct packed {
        t_action           action;
        logic [CODE_W-1:0] velocity;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] amplitude;
        t_phase             phase;
    } t_out_item;

    typedef struct packed {
        logic [CODE_W-1:0] attack_code;
        logic [CODE_W-1:0] decay_code;
        logic [CODE_W-1:0] sustain_code;
        logic [CODE_W-1:0] release_code;
        logic [CODE_W-1:0] sens_code;
        logic [TICK_W-1:0] tick_period;
    } t_cfg;

    // Controller -> datapath
    typedef struct packed {
        logic     accept;
        logic     tick;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     peak_load;
        logic     sus_load;
        logic     off_load;
        logic     step_load;
        logic     out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic div_done;
        logic peak_hit;
    } t_dp_stat;

endpackage

// ===== rtl/ladsr_div.sv =====
// ============================================================================
// ladsr_div
// Restoring divider, one quotient bit per cycle, quotient and remainder out.
// ============================================================================
module ladsr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ladsr_pkg::DIV_W-1:0]  i_num,
    input  logic [ladsr_pkg::MS_W-1:0]   i_den,
    output logic                         o_done,
    output logic [ladsr_pkg::DIV_W-1:0]  o_quo,
    output logic [ladsr_pkg::MS_W-1:0]   o_rem
);
    import ladsr_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W-1:0]   r_quo;
    logic [MS_W-1:0]    r_rem;
    logic [MS_W-1:0]    r_den;

    logic [MS_W:0]      n_shift;
    logic [MS_W:0]      n_diff;
    logic               n_fits;
    logic [MS_W-1:0]    n_rem;

    always_comb begin
        n_shift = {r_rem, r_quo[DIV_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_fits  = (n_shift >= {1'b0, r_den});
        n_rem   = n_fits ? n_diff[MS_W-1:0] : n_shift[MS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], n_fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/ladsr_dp.sv =====
// ============================================================================
// ladsr_dp
// Envelope datapath: level state, shared multiplier, divider, result register.
// ============================================================================
module ladsr_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ladsr_pkg::t_cfg       i_cfg,
    input  ladsr_pkg::t_in_item   i_in,
    input  ladsr_pkg::t_dp_cmd    i_cmd,
    output ladsr_pkg::t_dp_stat   o_stat,
    output ladsr_pkg::t_out_item  o_out
);
    import ladsr_pkg::*;

    // envelope state
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_target;
    logic [LEVEL_W-1:0] r_step;
    t_phase             r_phase;

    // working registers
    logic [CODE_W-1:0]  r_velocity;
    logic [LEVEL_W-1:0] r_diff;
    logic [CODE_W-1:0]  r_code;
    logic [PROD_W-1:0]  r_prod;
    t_out_item          r_out;

    logic [LEVEL_W-1:0] n_mul_a;
    logic [TICK_W-1:0]  n_mul_b;
    logic [PROD_W-1:0]  n_prod;
    logic [PROD_W:0]    n_round;
    logic [DIV_W-1:0]   n_div_num;
    logic [MS_W-1:0]    n_div_den;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic [MS_W-1:0]    div_rem;
    logic [LEVEL_W-1:0] n_quo_level;
    logic [DIV_W:0]     n_quo_up;
    logic [LEVEL_W-1:0] n_step_sat;
    logic [LEVEL_W:0]   n_attack_sum;
    logic [LEVEL_W-1:0] n_attack_lvl;
    logic               n_peak_hit;
    logic [LEVEL_W-1:0] n_gap;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_VEL: begin
                n_mul_a = LEVEL_W'(i_cfg.sens_code);
                n_mul_b = TICK_W'(CODE_MAX - r_velocity);
            end
            MUL_SUS: begin
                n_mul_a = r_target;
                n_mul_b = TICK_W'(i_cfg.sustain_code);
            end
            MUL_STEP: begin
                n_mul_a = r_diff;
                n_mul_b = i_cfg.tick_period;
            end
            default: begin
                n_mul_a = r_diff;
                n_mul_b = i_cfg.tick_period;
            end
        endcase
        n_prod = {{TICK_W{1'b0}}, n_mul_a} * {{LEVEL_W{1'b0}}, n_mul_b};
    end

    // divider operand select; Q8 tick is folded in by a ceiling shift first
    always_comb begin
        n_round = {1'b0, r_prod} + (PROD_W + 1)'(Q8_ROUND);
        case (i_cmd.div_sel)
            DIV_PEAK: begin
                n_div_num = {VEL_FULL - r_prod[VEL_NUM_W-1:0], {LEVEL_FRAC_BITS{1'b0}}};
                n_div_den = MS_W'(VEL_FULL);
            end
            DIV_SUS: begin
                n_div_num = DIV_W'(r_prod[LEVEL_W+CODE_W-1:0]);
                n_div_den = MS_W'(CODE_MAX);
            end
            DIV_STEP: begin
                n_div_num = DIV_W'(n_round[PROD_W:TICK_FRAC_BITS]);
                n_div_den = MS_TABLE[r_code];
            end
            default: begin
                n_div_num = DIV_W'(n_round[PROD_W:TICK_FRAC_BITS]);
                n_div_den = MS_TABLE[r_code];
            end
        endcase
    end

    ladsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // step = ceil(quotient), saturated to one
    always_comb begin
        n_quo_level = div_quo[LEVEL_W-1:0];
        n_quo_up    = {1'b0, div_quo} + (DIV_W + 1)'(div_rem != '0);
        n_step_sat  = (n_quo_up > (DIV_W + 1)'(ONE_LEVEL)) ? ONE_LEVEL
                                                           : n_quo_up[LEVEL_W-1:0];
    end

    // tick arithmetic
    always_comb begin
        n_attack_sum = {1'b0, r_level} + {1'b0, r_step};
        n_attack_lvl = (n_attack_sum > {1'b0, ONE_LEVEL}) ? ONE_LEVEL
                                                           : n_attack_sum[LEVEL_W-1:0];
        n_peak_hit   = (r_phase == PH_ATTACK) && (n_attack_lvl >= r_target);
        n_gap        = r_level - r_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_target <= '0;
            r_step   <= '0;
            r_phase  <= PH_IDLE;
        end else begin
            if (i_cmd.tick) begin
                case (r_phase)
                    PH_ATTACK: begin
                        r_level <= n_peak_hit ? r_target : n_attack_lvl;
                    end
                    PH_DECAY: begin
                        if (r_level > r_target) begin
                            r_level <= (n_gap > r_step) ? r_level - r_step : r_target;
                        end
                    end
                    PH_RELEASE: begin
                        if (r_level != '0) begin
                            r_level <= (r_level > r_step) ? r_level - r_step : '0;
                        end else begin
                            r_phase <= PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.peak_load) begin
                r_target <= n_quo_level;
                r_level  <= '0;
                r_phase  <= PH_ATTACK;
            end
            if (i_cmd.sus_load) begin
                r_target <= n_quo_level;
                r_phase  <= PH_DECAY;
            end
            if (i_cmd.off_load) begin
                r_target <= '0;
                r_phase  <= PH_RELEASE;
            end
            if (i_cmd.step_load) begin
                r_step <= n_step_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_velocity <= i_in.velocity;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.peak_load) begin
            r_diff <= n_quo_level;
            r_code <= i_cfg.attack_code;
        end
        if (i_cmd.sus_load) begin
            r_diff <= r_level - n_quo_level;
            r_code <= i_cfg.decay_code;
        end
        if (i_cmd.off_load) begin
            r_diff <= r_level;
            r_code <= i_cfg.release_code;
        end
        if (i_cmd.out_load) begin
            r_out.amplitude <= r_level;
            r_out.phase     <= r_phase;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.peak_hit = n_peak_hit;
    assign o_out           = r_out;

    // level stays inside [0, 1.0]
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= ONE_LEVEL)
        else $error("level above full scale");

endmodule

// ===== rtl/ladsr_ctrl.sv =====
// ============================================================================
// ladsr_ctrl
// Sequencer: walks items through any multiply and divide steps, owns handshakes.
// ============================================================================
module ladsr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  ladsr_pkg::t_action   i_action,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ladsr_pkg::t_dp_cmd   o_cmd,
    input  ladsr_pkg::t_dp_stat  i_stat
);
    import ladsr_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_TICK     = 10'b00_0000_0010,
        S_OFF      = 10'b00_0000_0100,
        S_VEL_MUL  = 10'b00_0000_1000,
        S_PEAK_DIV = 10'b00_0001_0000,
        S_SUS_MUL  = 10'b00_0010_0000,
        S_SUS_DIV  = 10'b00_0100_0000,
        S_STEP_MUL = 10'b00_1000_0000,
        S_STEP_DIV = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_div_wait;
    logic    n_div_wait;
    logic    r_out_valid;
    logic    slot_free;
    t_dp_cmd n_cmd;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_div_wait = r_div_wait;
        n_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.accept = 1'b1;
                    case (i_action)
                        ACT_TICK:     n_state = S_TICK;
                        ACT_NOTE_ON:  n_state = S_VEL_MUL;
                        ACT_NOTE_OFF: n_state = S_OFF;
                        default:      n_state = S_RESULT;
                    endcase
                end
            end
            S_TICK: begin
                n_cmd.tick = 1'b1;
                n_state    = i_stat.peak_hit ? S_SUS_MUL : S_RESULT;
            end
            S_OFF: begin
                n_cmd.off_load = 1'b1;
                n_state        = S_STEP_MUL;
            end
            S_VEL_MUL: begin
                n_cmd.mul_en  = 1'b1;
                n_cmd.mul_sel = MUL_VEL;
                n_state       = S_PEAK_DIV;
            end
            S_PEAK_DIV: begin
                n_cmd.div_sel = DIV_PEAK;
                if (!r_div_wait) begin
                    n_cmd.div_start = 1'b1;
                    n_div_wait      = 1'b1;
                end else if (i_stat.div_done) begin
                    n_cmd.peak_load = 1'b1;
                    n_div_wait      = 1'b0;
                    n_state         = S_STEP_MUL;
                end
            end
            S_SUS_MUL: begin
                n_cmd.mul_en  = 1'b1;
                n_cmd.mul_sel = MUL_SUS;
                n_state       = S_SUS_DIV;
            end
            S_SUS_DIV: begin
                n_cmd.div_sel = DIV_SUS;
                if (!r_div_wait) begin
                    n_cmd.div_start = 1'b1;
                    n_div_wait      = 1'b1;
                end else if (i_stat.div_done) begin
                    n_cmd.sus_load = 1'b1;
                    n_div_wait     = 1'b0;
                    n_state        = S_STEP_MUL;
                end
            end
            S_STEP_MUL: begin
                n_cmd.mul_en  = 1'b1;
                n_cmd.mul_sel = MUL_STEP;
                n_state       = S_STEP_DIV;
            end
            S_STEP_DIV: begin
                n_cmd.div_sel = DIV_STEP;
                if (!r_div_wait) begin
                    n_cmd.div_start = 1'b1;
                    n_div_wait      = 1'b1;
                end else if (i_stat.div_done) begin
                    n_cmd.step_load = 1'b1;
                    n_div_wait      = 1'b0;
                    n_state         = S_RESULT;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state    = S_IDLE;
                n_div_wait = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_wait  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_div_wait <= n_div_wait;
            if (n_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = n_cmd;

    // divider finishes only while a divide step waits on it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_div_wait &&
            (r_state == S_PEAK_DIV || r_state == S_SUS_DIV || r_state == S_STEP_DIV)))
        else $error("divider done outside a divide step");

    // a loaded result is presented on the next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cmd.out_load |=> o_out_valid)
        else $error("result load not presented");

    // one item in flight: no new item right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");

endmodule

// ===== rtl/linear_adsr_amplitude_envelope.sv =====
// ============================================================================
// linear_adsr_amplitude_envelope
// Linear ADSR amplitude envelope with velocity-scaled peak and time table.
// ============================================================================
// One item in, one result out, one item in flight at a time. A timer tick
// goes from its tick step straight to the result, except the tick on which
// the attack reaches its peak, which computes the sustain level and the decay
// step (sustain divide, then step divide). A note-on runs a peak divide, then
// a step divide, and a note-off a step divide only. How long an item takes is
// set by the shared restoring divider, which retires one quotient bit per
// cycle over a 38-bit dividend. A finished result sits in an
// output register, so the next item can be accepted while it waits.
// Amplitude is unsigned with 1.0 = 2^24; phase is 0 idle, 1 attack, 2 decay or
// sustain, 3 release. Configuration: index 0 attack time code, 1 decay time
// code, 2 sustain code, 3 release time code, 4 velocity sensitivity code,
// 5 tick period (ms, Q8.8); writes to other indexes are dropped. The port is
// always ready; write it only while no item is in flight.
// ============================================================================
module linear_adsr_amplitude_envelope (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  ladsr_pkg::t_in_item                   i_in,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output ladsr_pkg::t_out_item                  o_out,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ladsr_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ladsr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import ladsr_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // configuration registers; codes keep the low 7 bits of the write data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_code  <= TIME_CODE_RESET;
            r_cfg.decay_code   <= TIME_CODE_RESET;
            r_cfg.sustain_code <= SUSTAIN_RESET;
            r_cfg.release_code <= TIME_CODE_RESET;
            r_cfg.sens_code    <= SENS_RESET;
            r_cfg.tick_period  <= TICK_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ATTACK:  r_cfg.attack_code  <= i_cfg_data[CODE_W-1:0];
                CFG_DECAY:   r_cfg.decay_code   <= i_cfg_data[CODE_W-1:0];
                CFG_SUSTAIN: r_cfg.sustain_code <= i_cfg_data[CODE_W-1:0];
                CFG_RELEASE: r_cfg.release_code <= i_cfg_data[CODE_W-1:0];
                CFG_SENS:    r_cfg.sens_code    <= i_cfg_data[CODE_W-1:0];
                CFG_TICK:    r_cfg.tick_period  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer: handshakes and step order
    ladsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // envelope arithmetic and result register
    ladsr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule
